### sv/aesx_pkg.sv
// Package: shared types, constants and AES helper functions for the XTS sector engine.
`timescale 1ns / 1ps
package aesx_pkg;

  localparam int unsigned SECTOR_BYTES  = 4096;
  localparam int unsigned SECTOR_BLOCKS =
      (SECTOR_BYTES / 16 == 0) ? 1 : SECTOR_BYTES / 16;
  localparam int unsigned BIDX_W =
      (SECTOR_BLOCKS <= 1) ? 1 : $clog2(SECTOR_BLOCKS);
  localparam int unsigned NKEY_WORDS = 60;
  localparam int unsigned RKIDX_W    = 6;
  localparam int unsigned NREGS      = 8;
  localparam logic [7:0]  GF_POLY    = 8'h87;

  typedef enum logic [2:0] {
    REG_DATA_KEY_W0  = 3'd0,
    REG_DATA_KEY_W1  = 3'd1,
    REG_DATA_KEY_W2  = 3'd2,
    REG_DATA_KEY_W3  = 3'd3,
    REG_TWEAK_KEY_W0 = 3'd4,
    REG_TWEAK_KEY_W1 = 3'd5,
    REG_TWEAK_KEY_W2 = 3'd6,
    REG_TWEAK_KEY_W3 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [31:0] sector;
    logic        func;
  } in_beat_t;

  typedef struct packed {
    logic        last_of_sector;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_beat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h8d;
      3'd1:    r = 8'h01;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h04;
      3'd4:    r = 8'h08;
      3'd5:    r = 8'h10;
      3'd6:    r = 8'h20;
      default: r = 8'h40;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One column of MixColumns; byte r of the column in bits 8r.
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[7:0]; a1 = c[15:8]; a2 = c[23:16]; a3 = c[31:24];
    return {xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3),
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [31:0] o;
    for (int r = 0; r < 4; r++) begin
      a[r]  = c[8*r +: 8];
      m2[r] = xt(a[r]);
      m4[r] = xt(m2[r]);
      m8[r] = xt(m4[r]);
    end
    for (int r = 0; r < 4; r++) begin
      o[8*r +: 8] = (m8[r] ^ m4[r] ^ m2[r]) ^
                    (m8[(r+1)%4] ^ m2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (m8[(r+2)%4] ^ m4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (m8[(r+3)%4] ^ a[(r+3)%4]);
    end
    return o;
  endfunction

  // Forward round; state byte i at bits 8i.
  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last,
                                             input logic [127:0] rk);
    logic [127:0] t, m;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
    for (int c = 0; c < 4; c++)
      m[32*c +: 32] = mix_col(t[32*c +: 32]);
    return (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic last,
                                             input logic [127:0] rk);
    logic [127:0] t, m;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[8*(r+4*((c+r)%4)) +: 8] = inv_sbox(s[8*(r+4*c) +: 8]);
    t = t ^ rk;
    for (int c = 0; c < 4; c++)
      m[32*c +: 32] = inv_mix_col(t[32*c +: 32]);
    return last ? t : m;
  endfunction

endpackage

### sv/aesx_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aesx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/aesx_keysched.sv
// Key schedule: expands one 256-bit key into 60 round-key words, one word a cycle.
`timescale 1ns / 1ps
module aesx_keysched (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [255:0]                      key,
  input  logic [aesx_pkg::RKIDX_W-3:0]      rd_round,
  output logic [127:0]                      rd_key,
  output logic                              busy
);
  // Expansion runs a sliding window of the last eight words; each new word goes
  // to one of four RAM banks (word index mod 4) so a round key reads at once.
  logic [255:0] win_r, win_nxt;
  logic [5:0]   idx_r, idx_nxt;
  logic         busy_r, busy_nxt;
  logic [31:0]  t, w_new;
  logic [3:0]   we;

  always_comb begin
    t = win_r[255:224];
    if (idx_r[2:0] == 3'd0)
      t = aesx_pkg::sub_word({t[7:0], t[31:8]}) ^ {24'd0, aesx_pkg::rcon(idx_r[5:3])};
    else if (idx_r[2:0] == 3'd4)
      t = aesx_pkg::sub_word(t);
    w_new = (idx_r < 6'd8) ? key[32*idx_r[2:0] +: 32] : (win_r[31:0] ^ t);
  end

  always_comb begin
    win_nxt  = win_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (start) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      win_nxt = {w_new, win_r[255:32]};
      idx_nxt = idx_r + 6'd1;
      if (idx_r == 6'(aesx_pkg::NKEY_WORDS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    win_r <= win_nxt;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign we[b] = busy_r && !start && (idx_r[1:0] == 2'(b));
    aesx_ram #(.WIDTH(32), .DEPTH(16)) u_bank (
      .clk  (clk),
      .we   (we[b]),
      .waddr(idx_r[5:2]),
      .wdata(w_new),
      .raddr(rd_round),
      .rdata(rd_key[32*b +: 32])
    );
  end

  assign busy = busy_r;
endmodule

### sv/aes256_xts_sector_crypt.sv
// Top level: AES-256-XTS sector engine, one 16-byte block per beat.
`timescale 1ns / 1ps
// channel | ports                         | beat
// input   | in_valid  in_ready  in_data   | func, sector, data_lo, data_hi
// output  | out_valid out_ready out_data  | result_lo, result_hi, last_of_sector
// config  | cfg_we cfg_index cfg_wdata    | one 64-bit key word, no wait
// A block passes accept, whitening, 14 AES rounds (one a cycle from the round-key
// RAM, each key read while the step before runs) and the output cycle. The first
// block of a sector runs a tweak pass (whitening and 14 rounds) before its own.
// After reset the key schedules expand all 60 words (one word a cycle) before a
// block is taken; a key write holds input while it is written and while its key expansion runs.
// A result waiting in the output register stalls only the output cycle.
module aes256_xts_sector_crypt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aesx_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aesx_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [$clog2(aesx_pkg::NREGS)-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);
  typedef enum logic [1:0] {S_IDLE, S_TWEAK, S_DATA, S_OUT} state_t;

  state_t        state_r, state_nxt;
  logic [255:0]  dkey_r, tkey_r;
  logic [127:0]  tweak_r, tweak_nxt;
  logic [127:0]  st_r, st_nxt;
  logic [127:0]  blk_r, blk_nxt;
  logic [3:0]    rnd_r, rnd_nxt;
  logic          phase_r, phase_nxt;   // low in the first cycle of a pass: whitening
  logic          func_r, func_nxt;
  logic [aesx_pkg::BIDX_W-1:0] bidx_r, bidx_nxt;
  logic          out_valid_r, out_valid_nxt;
  aesx_pkg::out_beat_t out_r, out_nxt;

  logic          dstart, tstart, dbusy, tbusy;
  logic [127:0]  drk, trk, rk;
  logic [3:0]    rd_round, rnd_inc;
  logic          enc, last_blk, is_last_rnd;
  logic [127:0]  rnd_res;

  assign dstart = cfg_we && (cfg_index <= aesx_pkg::REG_DATA_KEY_W3);
  assign tstart = cfg_we && (cfg_index >= aesx_pkg::REG_TWEAK_KEY_W0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dkey_r <= '0;
      tkey_r <= '0;
    end else if (cfg_we) begin
      if (dstart) dkey_r[64*cfg_index[1:0] +: 64] <= cfg_wdata;
      else        tkey_r[64*cfg_index[1:0] +: 64] <= cfg_wdata;
    end
  end

  // Schedules take the key register as it stands after the write.
  aesx_keysched u_dks (
    .clk(clk), .rst_n(rst_n), .start(dstart), .key(dkey_r),
    .rd_round(rd_round), .rd_key(drk), .busy(dbusy));
  aesx_keysched u_tks (
    .clk(clk), .rst_n(rst_n), .start(tstart), .key(tkey_r),
    .rd_round(rd_round), .rd_key(trk), .busy(tbusy));

  assign enc      = (state_r == S_TWEAK) || func_r;
  assign rk       = (state_r == S_TWEAK) ? trk : drk;
  assign last_blk = (bidx_r == aesx_pkg::BIDX_W'(aesx_pkg::SECTOR_BLOCKS - 1));
  assign rnd_inc  = rnd_r + 4'd1;
  assign is_last_rnd = (rnd_r == 4'd14);
  // Key for the next round is read while the current round runs; the whitening key of a
  // pass is read in the cycle before it (accept, or last tweak round).
  assign rd_round = (state_r == S_IDLE) ? (((bidx_r == '0) || func_r) ? 4'd0 : 4'd14)
                  : (phase_r && is_last_rnd) ? (func_r ? 4'd0 : 4'd14)
                  : (enc ? rnd_inc : 4'd14 - rnd_inc);
  assign rnd_res  = enc ? aesx_pkg::fwd_round(st_r, is_last_rnd, rk)
                        : aesx_pkg::inv_round(st_r, is_last_rnd, rk);
  assign in_ready = (state_r == S_IDLE) && !dbusy && !tbusy && !dstart && !tstart;

  always_comb begin
    state_nxt     = state_r;
    tweak_nxt     = tweak_r;
    st_nxt        = st_r;
    blk_nxt       = blk_r;
    rnd_nxt       = rnd_r;
    phase_nxt     = phase_r;
    func_nxt      = func_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          blk_nxt   = {in_data.data_hi, in_data.data_lo};
          phase_nxt = 1'b0;
          rnd_nxt   = 4'd0;
          if (bidx_r == '0) begin
            func_nxt  = in_data.func;
            st_nxt    = {96'd0, in_data.sector};
            state_nxt = S_TWEAK;
          end else begin
            st_nxt    = {in_data.data_hi, in_data.data_lo} ^ tweak_r;
            state_nxt = S_DATA;
          end
        end
      end
      S_TWEAK, S_DATA: begin
        if (!phase_r) begin
          st_nxt    = st_r ^ rk;   // whitening
          phase_nxt = 1'b1;
          rnd_nxt   = rnd_inc;
        end else begin
          st_nxt  = rnd_res;
          rnd_nxt = rnd_inc;
          if (is_last_rnd) begin
            phase_nxt = 1'b0;
            rnd_nxt   = 4'd0;
            if (state_r == S_TWEAK) begin
              tweak_nxt = rnd_res;
              st_nxt    = blk_r ^ rnd_res;
              state_nxt = S_DATA;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.result_lo      = st_r[63:0] ^ tweak_r[63:0];
          out_nxt.result_hi      = st_r[127:64] ^ tweak_r[127:64];
          out_nxt.last_of_sector = last_blk;
          out_valid_nxt          = 1'b1;
          tweak_nxt = {tweak_r[126:0], 1'b0} ^
                      (tweak_r[127] ? {120'd0, aesx_pkg::GF_POLY} : 128'd0);
          bidx_nxt  = last_blk ? '0 : bidx_r + aesx_pkg::BIDX_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      func_r      <= 1'b0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      rnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      rnd_r       <= rnd_nxt;
    end
    tweak_r <= tweak_nxt;
    st_r    <= st_nxt;
    blk_r   <= blk_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

### sv/aesx_checker.sv
// Port-level checker for the sector engine, bound to the top level.
`timescale 1ns / 1ps
module aesx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input aesx_pkg::out_beat_t out_data,
  input logic                cfg_we
);
  // No block taken in the cycle of a key write.
  a_no_accept_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_ready) else $error("ready during key write");

  // Input is not ready again straight after an accepted block.
  a_in_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

  // Key write stalls input for at least the schedule; checked here only right after the write.
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready) else $error("ready during key expansion");
endmodule

bind aes256_xts_sector_crypt aesx_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
  .cfg_we(cfg_we));

### test/tb_aes256_xts_sector_crypt.sv
// Self-checking bench for the XTS sector engine: predicts each block and compares results.
`timescale 1ns / 1ps
module tb_aes256_xts_sector_crypt;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  aesx_pkg::in_beat_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  aesx_pkg::out_beat_t out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  aes256_xts_sector_crypt u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state
  logic [7:0]   sb [256];
  logic [7:0]   isb [256];
  logic [63:0]  dkey [4];
  logic [63:0]  tkey [4];
  logic [31:0]  drk [60];
  logic [31:0]  trk [60];
  logic [127:0] tweak;
  int unsigned  blk_pos;
  logic         dir;

  aesx_pkg::in_beat_t  block_q [$];
  aesx_pkg::out_beat_t cipher_q [$];
  int        errors = 0;
  int        gen_pos = 0;
  int        sectors_started = 0;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from GF(2^8) inverse plus affine map
  function automatic void build_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[x] = s;
      isb[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sub32(logic [31:0] w);
    return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
  endfunction

  function automatic void expand_keys(bit tw);
    logic [31:0] k [60];
    logic [31:0] t;
    logic [7:0]  rc [8];
    rc = '{8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    for (int i = 0; i < 8; i++) begin
      k[i] = tw ? tkey[i / 2][32 * (i % 2) +: 32] : dkey[i / 2][32 * (i % 2) +: 32];
    end
    for (int i = 8; i < 60; i++) begin
      t = k[i - 1];
      if (i % 8 == 0) t = sub32({t[7:0], t[31:8]}) ^ {24'h0, rc[(i / 8) % 8]};
      else if (i % 8 == 4) t = sub32(t);
      k[i] = k[i - 8] ^ t;
    end
    for (int i = 0; i < 60; i++) begin
      if (tw) trk[i] = k[i];
      else drk[i] = k[i];
    end
  endfunction

  function automatic logic [127:0] rkey(bit tw, int r);
    if (tw) return {trk[4*r+3], trk[4*r+2], trk[4*r+1], trk[4*r]};
    return {drk[4*r+3], drk[4*r+2], drk[4*r+1], drk[4*r]};
  endfunction

  function automatic logic [127:0] encrypt128(bit tw, logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    s ^= rkey(tw, 0);
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[8*(r+4*c) +: 8] = sb[s[8*(r+4*((c+r)%4)) +: 8]];
      if (rnd < 14) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = t[8*(4*c+r) +: 8];
          for (int r = 0; r < 4; r++)
            s[8*(4*c+r) +: 8] = gmul(a[r], 8'h02) ^ gmul(a[(r+1)%4], 8'h03)
                                ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
      end else begin
        s = t;
      end
      s ^= rkey(tw, rnd);
    end
    return s;
  endfunction

  function automatic logic [127:0] decrypt128(logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    s ^= rkey(1'b0, 14);
    for (int rnd = 13; rnd >= 0; rnd--) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[8*(r+4*((c+r)%4)) +: 8] = isb[s[8*(r+4*c) +: 8]];
      s = t ^ rkey(1'b0, rnd);
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[8*(4*c+r) +: 8];
          for (int r = 0; r < 4; r++)
            s[8*(4*c+r) +: 8] = gmul(a[r], 8'h0e) ^ gmul(a[(r+1)%4], 8'h0b)
                                ^ gmul(a[(r+2)%4], 8'h0d) ^ gmul(a[(r+3)%4], 8'h09);
        end
      end
    end
    return s;
  endfunction

  // one block through the sector engine; advances tweak and position
  function automatic aesx_pkg::out_beat_t xts_block(aesx_pkg::in_beat_t b);
    aesx_pkg::out_beat_t o;
    logic [127:0] x;
    if (blk_pos == 0) begin
      dir = b.func;
      tweak = encrypt128(1'b1, {96'h0, b.sector});
    end
    x = {b.data_hi, b.data_lo} ^ tweak;
    x = (dir ? encrypt128(1'b0, x) : decrypt128(x)) ^ tweak;
    o.result_lo = x[63:0];
    o.result_hi = x[127:64];
    o.last_of_sector = (blk_pos == aesx_pkg::SECTOR_BLOCKS - 1);
    tweak = {tweak[126:0], 1'b0} ^ (tweak[127] ? 128'h87 : 128'h0);
    blk_pos = o.last_of_sector ? 0 : blk_pos + 1;
    return o;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    logic     nv;
    aesx_pkg::in_beat_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_valid) cipher_q.push_back(xts_block(in_data));
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (block_q.size() > 0) begin
        nv = 1'b1;
        nd = block_q.pop_front();
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // monitor, receiver stall pattern and watchdog
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    aesx_pkg::out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data);
        errors++;
      end else begin
        e = cipher_q.pop_front();
        if (out_data.result_lo !== e.result_lo) begin
          $display("%0t: result_lo expected %h actual %h", $time, e.result_lo,
                   out_data.result_lo);
          errors++;
        end
        if (out_data.result_hi !== e.result_hi) begin
          $display("%0t: result_hi expected %h actual %h", $time, e.result_hi,
                   out_data.result_hi);
          errors++;
        end
        if (out_data.last_of_sector !== e.last_of_sector) begin
          $display("%0t: last_of_sector expected %b actual %b", $time,
                   e.last_of_sector, out_data.last_of_sector);
          errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else if (in_valid || cipher_q.size() > 0) idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("aes256_xts_sector_crypt regression: fail");
      $finish;
    end
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(8, 80);
    end
    mode_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_key(aesx_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < aesx_pkg::REG_TWEAK_KEY_W0) begin
      dkey[idx] = val;
      expand_keys(1'b0);
    end else begin
      tkey[idx - aesx_pkg::REG_TWEAK_KEY_W0] = val;
      expand_keys(1'b1);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_block(logic [127:0] data);
    aesx_pkg::in_beat_t b;
    b.func = 1'($urandom_range(0, 1));
    b.sector = $urandom;
    if (gen_pos == 0) begin
      // first blocks: max sector encrypt, zero sector decrypt, then random
      if (sectors_started == 0) begin
        b.func = 1'b1;
        b.sector = '1;
      end else if (sectors_started == 1) begin
        b.func = 1'b0;
        b.sector = '0;
      end
      sectors_started++;
    end
    b.data_lo = data[63:0];
    b.data_hi = data[127:64];
    block_q.push_back(b);
    gen_pos = (gen_pos == aesx_pkg::SECTOR_BLOCKS - 1) ? 0 : gen_pos + 1;
  endtask

  function automatic logic [127:0] rand_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic drain();
    wait (block_q.size() == 0 && !in_valid && cipher_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [127:0] d;
    build_sbox();
    for (int i = 0; i < 4; i++) begin
      dkey[i] = '0;
      tkey[i] = '0;
    end
    expand_keys(1'b0);
    expand_keys(1'b1);
    tweak = '0;
    blk_pos = 0;
    dir = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero keys, data extremes and walking bits
    for (int i = 0; i < 25; i++) begin
      case (i)
        0: d = '0;
        1: d = '1;
        2: d = {32{4'ha}};
        3: d = {32{4'h5}};
        default: d = 128'h1 << ((i - 4) * 6);
      endcase
      queue_block(d);
    end
    drain();

    for (int ph = 1; ph <= 6; ph++) begin
      for (int r = 0; r < 8; r++) begin
        case (ph)
          1: write_key(aesx_pkg::reg_idx_t'(r), '1);
          2, 6: write_key(aesx_pkg::reg_idx_t'(r), {$urandom, $urandom});
          3: if (r < 4) write_key(aesx_pkg::reg_idx_t'(r), {$urandom, $urandom});
          4: write_key(aesx_pkg::reg_idx_t'(r), '0);
          default: if (r >= 4) write_key(aesx_pkg::reg_idx_t'(r), {$urandom, $urandom});
        endcase
      end
      for (int i = 0; i < 100; i++) queue_block(rand_block());
      drain();
    end

    if (errors == 0) $display("aes256_xts_sector_crypt regression: pass");
    else $display("aes256_xts_sector_crypt regression: fail");
    $finish;
  end

endmodule

### filelist.f
sv/aesx_pkg.sv
sv/aesx_ram.sv
sv/aesx_keysched.sv
sv/aes256_xts_sector_crypt.sv
sv/aesx_checker.sv
test/tb_aes256_xts_sector_crypt.sv
